// File: src/mpca_pkg.sv
package mpca_pkg;

    // Default sizing
    localparam int MPCA_MAX_NODES = 16;
    localparam int MPCA_FRAC_BITS = 24;

    // Field widths fixed by the interface
    localparam int RATE_W  = 32;
    localparam int NODE_W  = 4;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [RATE_W-1:0] SAT32 = 32'hFFFF_FFFF;

    // Reset value of node_count
    localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 5'd16;

    // Register indexes
    localparam logic REG_NODE_COUNT = 1'b0;

    // Input operations
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_PROFIT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NODE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

    // One input item
    typedef struct packed {
        logic              operation;
        logic [NODE_W-1:0] src_node;
        logic [NODE_W-1:0] dst_node;
        logic [RATE_W-1:0] rate;
    } t_item;

    // One result beat from the sequencer
    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [RATE_W-1:0] profit;
        logic [NODE_W-1:0] node;
        logic              last;
    } t_beat;

endpackage

// File: src/mpca_core.sv
module mpca_core #(
    parameter int MAX_NODES      = mpca_pkg::MPCA_MAX_NODES,
    parameter int RATE_FRAC_BITS = mpca_pkg::MPCA_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [mpca_pkg::COUNT_W-1:0]     i_node_count,
    input  logic                             i_in_valid,
    input  mpca_pkg::t_item                  i_item,
    output logic                             o_in_ready,
    input  logic                             i_beat_free,
    output mpca_pkg::t_beat                  o_beat
);
    import mpca_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int AW    = 2 * NW;
    localparam int DEPTH = 1 << AW;
    localparam int DW    = RATE_W + NW + 1;
    localparam int WW    = $clog2(MAX_NODES + 2);

    localparam logic [RATE_W-1:0] FX_ONE =
        (RATE_FRAC_BITS >= 32) ? SAT32 : RATE_W'(64'd1 << RATE_FRAC_BITS);

    // Sequencer states
    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_LOAD      = 4'd1;
    localparam logic [3:0] S_FW_IK     = 4'd2;
    localparam logic [3:0] S_FW_IKD    = 4'd3;
    localparam logic [3:0] S_FW_RD     = 4'd4;
    localparam logic [3:0] S_FW_MUL    = 4'd5;
    localparam logic [3:0] S_FW_UPD    = 4'd6;
    localparam logic [3:0] S_SR_RD     = 4'd7;
    localparam logic [3:0] S_SR_CMP    = 4'd8;
    localparam logic [3:0] S_EM_NONE   = 4'd9;
    localparam logic [3:0] S_EM_PROFIT = 4'd10;
    localparam logic [3:0] S_WK_RD     = 4'd11;
    localparam logic [3:0] S_WK_EM     = 4'd12;
    localparam logic [3:0] S_WK_LAST   = 4'd13;

    logic [3:0]        r_state, n_state;
    logic [AW-1:0]     r_clr;
    logic [NW-1:0]     r_k, r_i, r_j, r_nm1;
    logic [RATE_W-1:0] r_pik;
    logic [NW-1:0]     r_hik;
    logic              r_vik;
    logic [63:0]       r_prod;
    logic [RATE_W-1:0] r_pij;
    logic [RATE_W-1:0] r_best_val;
    logic [NW-1:0]     r_best;
    logic              r_found;
    logic [NW-1:0]     r_cur;
    logic [WW-1:0]     r_walk;

    // Matrix memory: {product, next hop, hop valid} per (row, col)
    logic [DW-1:0]     r_mem [DEPTH];
    logic [DW-1:0]     r_rd_a, r_rd_b;
    logic [AW-1:0]     addr_a, addr_b, mem_waddr;
    logic [DW-1:0]     mem_wdata;
    logic              mem_we;

    logic [RATE_W-1:0] rd_a_prod, rd_b_prod;
    logic [NW-1:0]     rd_a_hop;
    logic              rd_a_vld;
    logic [63:0]       prod_sh;
    logic [RATE_W-1:0] sat;
    logic              grow;
    logic [NW-1:0]     clr_row, clr_col;
    logic [NW-1:0]     nm1_cfg;
    logic              edge_ok;
    logic              cmp_hit;
    logic [WW-1:0]     walk_next;
    logic              walk_done;
    logic              fw_done;

    assign rd_a_prod = r_rd_a[DW-1 -: RATE_W];
    assign rd_a_hop  = r_rd_a[NW:1];
    assign rd_a_vld  = r_rd_a[0];
    assign rd_b_prod = r_rd_b[DW-1 -: RATE_W];

    // Fixed-point rescale and saturation of the registered product
    assign prod_sh = r_prod >> RATE_FRAC_BITS;
    assign sat     = (|prod_sh[63:32]) ? SAT32 : prod_sh[31:0];
    assign grow    = sat > r_pij;

    assign clr_row = r_clr[AW-1:NW];
    assign clr_col = r_clr[NW-1:0];

    assign edge_ok = (32'(i_item.src_node) < MAX_NODES) &&
                     (32'(i_item.dst_node) < MAX_NODES);

    // Active node count, clamped to 1..MAX_NODES, kept as n-1
    always_comb begin
        if (i_node_count == '0) begin
            nm1_cfg = '0;
        end else if (32'(i_node_count) > MAX_NODES) begin
            nm1_cfg = NW'(MAX_NODES - 1);
        end else begin
            nm1_cfg = NW'(32'(i_node_count) - 32'd1);
        end
    end

    assign cmp_hit   = rd_a_prod > r_best_val;
    assign walk_next = r_walk + WW'(1);
    assign walk_done = walk_next == (WW'(r_nm1) + WW'(2));
    assign fw_done   = (r_j == r_nm1) && (r_i == r_nm1) && (r_k == r_nm1);

    // Memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    // Sequencer control and memory port selection
    always_comb begin
        n_state    = r_state;
        o_in_ready = (r_state == S_LOAD);
        addr_a     = {r_i, r_k};
        addr_b     = {r_i, r_j};
        mem_we     = 1'b0;
        mem_waddr  = {r_i, r_j};
        mem_wdata  = {sat, r_hik, r_vik};
        o_beat     = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = (clr_row == clr_col) ? {FX_ONE, clr_col, 1'b1} : '0;
                if (&r_clr) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_in_valid) begin
                    if (i_item.operation == OP_LOAD) begin
                        mem_we    = edge_ok;
                        mem_waddr = {NW'(i_item.src_node), NW'(i_item.dst_node)};
                        mem_wdata = {i_item.rate, NW'(i_item.dst_node), 1'b1};
                    end else begin
                        n_state = S_FW_IK;
                    end
                end
            end
            S_FW_IK: begin
                addr_a  = {r_i, r_k};
                n_state = S_FW_IKD;
            end
            S_FW_IKD: begin
                n_state = S_FW_RD;
            end
            S_FW_RD: begin
                addr_a  = {r_k, r_j};
                addr_b  = {r_i, r_j};
                n_state = S_FW_MUL;
            end
            S_FW_MUL: begin
                n_state = S_FW_UPD;
            end
            S_FW_UPD: begin
                mem_we    = grow;
                mem_waddr = {r_i, r_j};
                if (r_j != r_nm1) begin
                    n_state = S_FW_RD;
                end else if (!fw_done) begin
                    n_state = S_FW_IK;
                end else begin
                    n_state = S_SR_RD;
                end
            end
            S_SR_RD: begin
                addr_a  = {r_i, r_i};
                n_state = S_SR_CMP;
            end
            S_SR_CMP: begin
                if (r_i != r_nm1) begin
                    n_state = S_SR_RD;
                end else if (r_found || cmp_hit) begin
                    n_state = S_EM_PROFIT;
                end else begin
                    n_state = S_EM_NONE;
                end
            end
            S_EM_NONE: begin
                o_beat.valid = 1'b1;
                o_beat.kind  = KIND_NONE;
                o_beat.last  = 1'b1;
                if (i_beat_free) begin
                    n_state = S_CLEAR;
                end
            end
            S_EM_PROFIT: begin
                o_beat.valid  = 1'b1;
                o_beat.kind   = KIND_PROFIT;
                o_beat.profit = r_best_val;
                if (i_beat_free) begin
                    n_state = S_WK_RD;
                end
            end
            S_WK_RD: begin
                addr_a  = {r_cur, r_best};
                n_state = S_WK_EM;
            end
            S_WK_EM: begin
                addr_a       = {r_cur, r_best};
                o_beat.valid = 1'b1;
                o_beat.kind  = KIND_NODE;
                o_beat.node  = NODE_W'(r_cur);
                if (i_beat_free) begin
                    if (!rd_a_vld || (rd_a_hop == r_best) || walk_done) begin
                        n_state = S_WK_LAST;
                    end else begin
                        n_state = S_WK_RD;
                    end
                end
            end
            S_WK_LAST: begin
                o_beat.valid = 1'b1;
                o_beat.kind  = KIND_NODE;
                o_beat.node  = NODE_W'(r_best);
                o_beat.last  = 1'b1;
                if (i_beat_free) begin
                    n_state = S_CLEAR;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State and clear sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    // Loop counters and datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                if (i_in_valid && (i_item.operation == OP_END)) begin
                    r_nm1 <= nm1_cfg;
                    r_k   <= '0;
                    r_i   <= '0;
                    r_j   <= '0;
                end
            end
            S_FW_IKD: begin
                r_pik <= rd_a_prod;
                r_hik <= rd_a_hop;
                r_vik <= rd_a_vld;
            end
            S_FW_MUL: begin
                r_prod <= r_pik * rd_a_prod;
                r_pij  <= rd_b_prod;
            end
            S_FW_UPD: begin
                // the cached row head follows its own update
                if (grow && (r_j == r_k)) begin
                    r_pik <= sat;
                end
                if (r_j != r_nm1) begin
                    r_j <= r_j + NW'(1);
                end else begin
                    r_j <= '0;
                    if (r_i != r_nm1) begin
                        r_i <= r_i + NW'(1);
                    end else begin
                        r_i <= '0;
                        r_k <= r_k + NW'(1);
                    end
                end
                if (fw_done) begin
                    r_best_val <= FX_ONE;
                    r_best     <= '0;
                    r_found    <= 1'b0;
                end
            end
            S_SR_CMP: begin
                if (cmp_hit) begin
                    r_best_val <= rd_a_prod;
                    r_best     <= r_i;
                    r_found    <= 1'b1;
                end
                if (r_i != r_nm1) begin
                    r_i <= r_i + NW'(1);
                end
            end
            S_EM_PROFIT: begin
                if (i_beat_free) begin
                    r_cur  <= r_best;
                    r_walk <= '0;
                end
            end
            S_WK_EM: begin
                if (i_beat_free) begin
                    r_walk <= walk_next;
                    r_cur  <= rd_a_hop;
                end
            end
            default: begin
            end
        endcase
    end

    // Checks
    a_clear_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) && (&r_clr) |=> (r_state == S_LOAD))
        else $error("clear sweep did not return to loading");

    a_fw_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FW_UPD) |-> (r_k <= r_nm1) && (r_i <= r_nm1) && (r_j <= r_nm1))
        else $error("closure index beyond active nodes");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WK_EM) |-> (r_walk <= (WW'(r_nm1) + WW'(1))))
        else $error("cycle walk too long");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_beat.valid && o_beat.last && i_beat_free |=> (r_state == S_CLEAR))
        else $error("final beat not followed by clear sweep");

    a_search_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SR_RD) && !r_found |-> (r_best_val == FX_ONE))
        else $error("search threshold lost");

    a_ready_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_beat.valid)
        else $error("result offered while loading");

endmodule

// File: src/max_product_closure_arbitrage_top.sv
// Max-product path closure with arbitrage cycle report.
// Input channel (i_in_valid / o_in_stall): edge loads (operation 0) are taken one
// per cycle and written straight into the matrix memory. An end item (operation 1)
// starts the closure over the first node_count nodes; the input stalls until the
// report has passed to the output register and the matrices are back to identity.
// Work per end item, n = clamped node_count, C = 2^(2*ceil(log2(MAX_NODES))):
//   closure over all n*n*n (k, i, j) steps through one shared 32x32 multiply/compare
//   unit with a write-back to the matrix memory, then a search of the n diagonal
//   entries, the profit or no-arbitrage beat, one beat per walked cycle node, one
//   for the closing node, then a clear sweep of all C entries (256 at MAX_NODES = 16).
// Output channel (o_out_valid / i_out_stall): results leave through an output
// register; while the receiver stalls, the register holds its beat and the
// sequencer waits. A report is profit, path nodes, closing node (o_last), or a
// single no-arbitrage beat with o_last set.
// Reset (synchronous, active low) sets node_count to 16 and runs the same clear
// sweep before the first item is taken. The APB port writes node_count.
module max_product_closure_arbitrage_top #(
    parameter int MAX_NODES      = mpca_pkg::MPCA_MAX_NODES,
    parameter int RATE_FRAC_BITS = mpca_pkg::MPCA_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_operation,
    input  logic [mpca_pkg::NODE_W-1:0]   i_src_node,
    input  logic [mpca_pkg::NODE_W-1:0]   i_dst_node,
    input  logic [mpca_pkg::RATE_W-1:0]   i_rate,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mpca_pkg::KIND_W-1:0]   o_kind,
    output logic [mpca_pkg::RATE_W-1:0]   o_profit,
    output logic [mpca_pkg::NODE_W-1:0]   o_node,
    output logic                          o_last
);
    import mpca_pkg::*;

    logic [COUNT_W-1:0] r_node_count;
    logic               cfg_wr;
    logic               reg_idx;
    t_item              item;
    t_beat              beat;
    logic               in_ready;
    logic               beat_free;
    logic               r_out_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [RATE_W-1:0]  r_profit;
    logic [NODE_W-1:0]  r_node;
    logic               r_last;

    // Register file: node_count only
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
        end else if (cfg_wr && (reg_idx == REG_NODE_COUNT)) begin
            r_node_count <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NODE_COUNT: prdata = 32'(r_node_count);
            default:        prdata = '0;
        endcase
    end

    // Input beat
    assign item.operation = i_operation;
    assign item.src_node  = i_src_node;
    assign item.dst_node  = i_dst_node;
    assign item.rate      = i_rate;
    assign o_in_stall     = !in_ready;

    mpca_core #(
        .MAX_NODES      (MAX_NODES),
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_node_count (r_node_count),
        .i_in_valid   (i_in_valid),
        .i_item       (item),
        .o_in_ready   (in_ready),
        .i_beat_free  (beat_free),
        .o_beat       (beat)
    );

    // Output register
    assign beat_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (beat_free) begin
            r_out_valid <= beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat_free && beat.valid) begin
            r_kind   <= beat.kind;
            r_profit <= beat.profit;
            r_node   <= beat.node;
            r_last   <= beat.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_profit    = r_profit;
    assign o_node      = r_node;
    assign o_last      = r_last;

endmodule
